/* rtl/matrix_inverse_3x3_macros.svh */
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Both macros expect signals named clock and reset in the calling scope.
`define MI3_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mi3_pkg.sv */
// Shared constants for the 3x3 matrix inverse.
package mi3_pkg;

   localparam int ElemWidthDefault = 32;
   localparam int FracBitsDefault  = 16;
   localparam int NumElems         = 9;
   localparam int QueueDepth       = 4;
   localparam int SingularBit      = 0;
   localparam int SaturatedBit     = 1;
   localparam int UserWidth        = 2;

endpackage

/* rtl/matrix_inverse_3x3.sv */
// Top level of the 3x3 matrix inverse by adjugate over determinant.
//
//   Channel | Direction | Carries
//   req_    | in        | nine matrix elements in tdata
//   rsp_    | out       | nine inverse elements and determinant in tdata, flags in tuser
//
// One transaction is accepted per cycle while the queue is not full; the front and back pipelines
// each take one per cycle unless stalled. The back pipeline produces one quotient bit per stage.
// Reset clears only valid bits and the queue pointers and count; the datapath needs no clearing.
// A stall on rsp_ freezes the back pipeline; the front keeps filling the queue until full.
`include "matrix_inverse_3x3_macros.svh"
module matrix_inverse_3x3 #(
   parameter int ELEM_WIDTH = mi3_pkg::ElemWidthDefault,
   parameter int FRAC_BITS  = mi3_pkg::FracBitsDefault
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0 .. elem_r2c2
   input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0 .. inv_r2c2, det_value
   output logic [((10*ELEM_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // singular, saturated
   output logic [mi3_pkg::UserWidth-1:0]              rsp_tuser
);
   import mi3_pkg::*;

   localparam int W      = ELEM_WIDTH;
   localparam int QWIDTH = 9*(2*W+1) + 3*W + 4;

   logic [NumElems-1:0][W-1:0] elem;
   logic [NumElems-1:0][W-1:0] inv;
   logic [W-1:0]               det;
   logic                       singular;
   logic                       saturated;
   logic                       q_full;
   logic                       q_push;
   logic                       q_pop;
   logic                       q_head_valid;
   logic [QWIDTH-1:0]          q_push_data;
   logic [QWIDTH-1:0]          q_head_data;

   always_comb begin
      for (int i = 0; i < NumElems; i++) begin
         elem[i] = req_tdata[i*W +: W];
      end
   end

   mi3_front #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_elem (elem),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_push_data)
   );

   mi3_queue #(
      .DATA_WIDTH(QWIDTH),
      .DEPTH     (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_head_valid),
      .head_data (q_head_data)
   );

   mi3_back #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_data    (q_head_data),
      .pop          (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_inv      (inv),
      .out_det      (det),
      .out_singular (singular),
      .out_saturated(saturated)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NumElems; i++) begin
         rsp_tdata[i*W +: W] = inv[i];
      end
      rsp_tdata[NumElems*W +: W] = det;
      rsp_tuser                  = '0;
      rsp_tuser[SingularBit]     = singular;
      rsp_tuser[SaturatedBit]    = saturated;
   end

   `MI3_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "Push into a full queue.")
   `MI3_ASSERT_NOW(a_singular_zero, rsp_tvalid && singular, !saturated && rsp_tdata[10*W-1:0] == '0, "Singular result is not all zero.")
   `MI3_ASSERT_NOW(a_pop_needs_room, q_pop, !rsp_tvalid || rsp_tready, "Queue popped while the output stalls.")
   `MI3_ASSERT_NEXT(a_full_blocks_input, q_full && !q_pop, q_full || !q_push, "Queue state inconsistent after full.")

endmodule

/* rtl/mi3_front.sv */
// Front pipeline: cofactors, determinant and singular classification.
module mi3_front #(
   parameter int ELEM_WIDTH = mi3_pkg::ElemWidthDefault
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic [mi3_pkg::NumElems-1:0][ELEM_WIDTH-1:0] in_elem,
   input  logic                                         q_full,
   output logic                                         q_push,
   output logic [9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+3:0]   q_data
);
   import mi3_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2*W;
   localparam int AW = 2*W+1;
   localparam int DW = 3*W+3;

   logic                 en;
   logic [4:0]           vld_ff;
   logic signed [PW-1:0] pa_in [NumElems];
   logic signed [PW-1:0] pb_in [NumElems];
   logic signed [PW-1:0] pa_ff [NumElems];
   logic signed [PW-1:0] pb_ff [NumElems];
   logic signed [W-1:0]  row1_ff [3];
   logic signed [W-1:0]  row2_ff [3];
   logic signed [AW-1:0] adj2_ff [NumElems];
   logic signed [AW-1:0] adj3_ff [NumElems];
   logic signed [AW-1:0] adj4_ff [NumElems];
   logic signed [AW-1:0] adj5_ff [NumElems];
   logic signed [2*W:0]  pl_ff [3];
   logic signed [2*W:0]  ph_ff [3];
   logic signed [3*W:0]  pc_ff [3];
   logic signed [DW-1:0] det5_ff;

   assign en       = !q_full;
   assign in_ready = en;
   assign q_push   = vld_ff[4] && en;

   for (genvar gi = 0; gi < NumElems; gi++) begin : g_cof
      localparam int R  = gi / 3;
      localparam int C  = gi % 3;
      localparam int R0 = (C + 1) % 3;
      localparam int R1 = (C + 2) % 3;
      localparam int C0 = (R + 1) % 3;
      localparam int C1 = (R + 2) % 3;
      assign pa_in[gi] = $signed(in_elem[R0*3+C0]) * $signed(in_elem[R1*3+C1]);
      assign pb_in[gi] = $signed(in_elem[R0*3+C1]) * $signed(in_elem[R1*3+C0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NumElems; i++) begin
            pa_ff[i]   <= pa_in[i];
            pb_ff[i]   <= pb_in[i];
            adj2_ff[i] <= $signed({pa_ff[i][PW-1], pa_ff[i]})
                          - $signed({pb_ff[i][PW-1], pb_ff[i]});
            adj3_ff[i] <= adj2_ff[i];
            adj4_ff[i] <= adj3_ff[i];
            adj5_ff[i] <= adj4_ff[i];
         end
         for (int c = 0; c < 3; c++) begin
            row1_ff[c] <= $signed(in_elem[c]);
            row2_ff[c] <= row1_ff[c];
            pl_ff[c]   <= row2_ff[c] * $signed({1'b0, adj2_ff[c*3][W-1:0]});
            ph_ff[c]   <= row2_ff[c] * $signed(adj2_ff[c*3][AW-1:W]);
            pc_ff[c]   <= $signed({ph_ff[c], {W{1'b0}}})
                          + $signed({{W{pl_ff[c][2*W]}}, pl_ff[c]});
         end
         det5_ff <= $signed({{2{pc_ff[0][3*W]}}, pc_ff[0]})
                    + $signed({{2{pc_ff[1][3*W]}}, pc_ff[1]})
                    + $signed({{2{pc_ff[2][3*W]}}, pc_ff[2]});
      end
   end

   always_comb begin
      for (int i = 0; i < NumElems; i++) begin
         q_data[i*AW +: AW] = adj5_ff[i];
      end
      q_data[NumElems*AW +: DW] = det5_ff;
      q_data[NumElems*AW+DW]    = (det5_ff == '0);
   end

endmodule

/* rtl/mi3_queue.sv */
// Small register queue between the front and back pipelines.
module mi3_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = mi3_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output logic [DATA_WIDTH-1:0] head_data
);
   import mi3_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == IW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == IW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/mi3_back.sv */
// Back pipeline: restoring division of each cofactor by the determinant.
module mi3_back #(
   parameter int ELEM_WIDTH = mi3_pkg::ElemWidthDefault,
   parameter int FRAC_BITS  = mi3_pkg::FracBitsDefault
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         head_valid,
   input  logic [9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+3:0]   head_data,
   output logic                                         pop,
   output logic                                         out_valid,
   input  logic                                         out_ready,
   output logic [mi3_pkg::NumElems-1:0][ELEM_WIDTH-1:0] out_inv,
   output logic [ELEM_WIDTH-1:0]                        out_det,
   output logic                                         out_singular,
   output logic                                         out_saturated
);
   import mi3_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int AW = 2*W+1;
   localparam int DW = 3*W+3;
   localparam int QB = W+1;
   localparam int NQ = QB+1;
   localparam int NS = NQ;
   localparam int NW = AW + 2*FRAC_BITS;
   localparam int RW = ((NW > DW+QB) ? NW : DW+QB) + 1;

   logic               en;
   logic [NS:0]        vld_ff;
   logic [RW-1:0]      rem_ff [NS+1][NumElems];
   logic [RW-1:0]      rem_in [NS+1][NumElems];
   logic [NQ-1:0]      q_ff   [NS+1][NumElems];
   logic [NQ-1:0]      q_in   [NS+1][NumElems];
   logic               neg_ff [NS+1][NumElems];
   logic               neg_in [NS+1][NumElems];
   logic [RW-1:0]      den_ff [NS+1];
   logic [RW-1:0]      den_in [NS+1];
   logic               sing_ff [NS+1];
   logic               sing_in [NS+1];
   logic [W-1:0]       dval_ff [NS+1];
   logic [W-1:0]       dval_in [NS+1];
   logic               dclip_ff [NS+1];
   logic               dclip_in [NS+1];
   logic [AW-1:0]      adj_u;
   logic [AW-1:0]      amag;
   logic [DW-1:0]      det_u;
   logic [DW-1:0]      dmag;
   logic [DW-1:0]      detq;
   logic               dneg;
   logic [RW-1:0]      dsh;
   logic               ge;
   logic [NQ-1:0]      qv;
   logic               clip_p;
   logic               clip_n;
   logic               any_clip;
   logic [W-1:0]       inv_in [NumElems];
   logic               sat_in;
   logic               out_valid_ff;
   logic [W-1:0]       inv_ff [NumElems];
   logic [W-1:0]       det_ff;
   logic               sing_out_ff;
   logic               sat_ff;

   assign en        = !out_valid_ff || out_ready;
   assign pop       = en && head_valid;
   assign out_valid = out_valid_ff;

   always_comb begin
      det_u = head_data[NumElems*AW +: DW];
      dneg  = det_u[DW-1];
      dmag  = dneg ? (~det_u + 1'b1) : det_u;
      detq  = dmag >> (2*FRAC_BITS);
      den_in[0]   = RW'(dmag);
      sing_in[0]  = head_data[NumElems*AW+DW];
      dclip_in[0] = (!dneg && detq >= (DW'(1) << (W-1)))
                    || (dneg && detq > (DW'(1) << (W-1)));
      if (!dneg && detq >= (DW'(1) << (W-1))) begin
         dval_in[0] = {1'b0, {(W-1){1'b1}}};
      end else if (dneg && detq > (DW'(1) << (W-1))) begin
         dval_in[0] = {1'b1, {(W-1){1'b0}}};
      end else if (dneg) begin
         dval_in[0] = ~detq[W-1:0] + 1'b1;
      end else begin
         dval_in[0] = detq[W-1:0];
      end
      for (int i = 0; i < NumElems; i++) begin
         adj_u        = head_data[i*AW +: AW];
         amag         = adj_u[AW-1] ? (~adj_u + 1'b1) : adj_u;
         rem_in[0][i] = RW'(amag) << (2*FRAC_BITS);
         q_in[0][i]   = '0;
         neg_in[0][i] = adj_u[AW-1] ^ dneg;
      end
      for (int s = 0; s < NS; s++) begin
         dsh           = den_ff[s] << (NQ - 1 - s);
         den_in[s+1]   = den_ff[s];
         sing_in[s+1]  = sing_ff[s];
         dval_in[s+1]  = dval_ff[s];
         dclip_in[s+1] = dclip_ff[s];
         for (int i = 0; i < NumElems; i++) begin
            ge             = (rem_ff[s][i] >= dsh);
            rem_in[s+1][i] = ge ? (rem_ff[s][i] - dsh) : rem_ff[s][i];
            q_in[s+1][i]   = q_ff[s][i] | (NQ'(ge) << (NQ - 1 - s));
            neg_in[s+1][i] = neg_ff[s][i];
         end
      end
   end

   always_comb begin
      any_clip = 1'b0;
      for (int i = 0; i < NumElems; i++) begin
         qv     = q_ff[NS][i];
         clip_p = !neg_ff[NS][i] && (qv >= (NQ'(1) << (W-1)));
         clip_n = neg_ff[NS][i] && (qv > (NQ'(1) << (W-1)));
         if (sing_ff[NS]) begin
            inv_in[i] = '0;
         end else if (clip_p) begin
            inv_in[i] = {1'b0, {(W-1){1'b1}}};
         end else if (clip_n) begin
            inv_in[i] = {1'b1, {(W-1){1'b0}}};
         end else if (neg_ff[NS][i]) begin
            inv_in[i] = ~qv[W-1:0] + 1'b1;
         end else begin
            inv_in[i] = qv[W-1:0];
         end
         any_clip = any_clip | clip_p | clip_n;
      end
      sat_in = !sing_ff[NS] && (any_clip || dclip_ff[NS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NS-1:0], head_valid};
         out_valid_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= NS; s++) begin
            den_ff[s]   <= den_in[s];
            sing_ff[s]  <= sing_in[s];
            dval_ff[s]  <= dval_in[s];
            dclip_ff[s] <= dclip_in[s];
            for (int i = 0; i < NumElems; i++) begin
               rem_ff[s][i] <= rem_in[s][i];
               q_ff[s][i]   <= q_in[s][i];
               neg_ff[s][i] <= neg_in[s][i];
            end
         end
         for (int i = 0; i < NumElems; i++) begin
            inv_ff[i] <= inv_in[i];
         end
         det_ff      <= dval_ff[NS];
         sing_out_ff <= sing_ff[NS];
         sat_ff      <= sat_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NumElems; i++) begin
         out_inv[i] = inv_ff[i];
      end
   end

   assign out_det       = det_ff;
   assign out_singular  = sing_out_ff;
   assign out_saturated = sat_ff;

endmodule
